/* design/ihfc_pkg.sv */
// ----------------------------------------------------------------------------
// Incubator heater and fan control package
// Shared constants: widths, register indexes, reset values and limits.
// ----------------------------------------------------------------------------
package ihfc_pkg;

	localparam int TEMP_WIDTH_DEF = 12;
	localparam int TICK_WIDTH_DEF = 16;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET    = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AMBIENT   = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BALANCE   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOSS      = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAN_REST  = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAN_RUN   = 3'd6;

	localparam logic        [10:0] TARGET_RST    = 11'd432;
	localparam logic signed [11:0] AMBIENT_RST   = 12'sd288;
	localparam logic        [9:0]  BALANCE_RST   = 10'd46;
	localparam logic        [10:0] LOSS_RST      = 11'd640;
	localparam logic        [7:0]  TOLERANCE_RST = 8'd8;
	localparam logic        [15:0] FAN_REST_RST  = 16'd10000;
	localparam logic        [15:0] FAN_RUN_RST   = 16'd100;

	localparam int LOW_LIMIT  = 160;
	localparam int HIGH_LIMIT = 640;
	localparam int LOAD_LIMIT = 8;
	localparam longint TICK_RESET = 20000;

endpackage

/* design/incubator_heater_fan_control.sv */
// ----------------------------------------------------------------------------
// Incubator heater and fan control
// Validates inside and water readings, then runs a hysteresis heater
// controller and a timed fan controller.
//
// Usage: one input beat (inside_temp, water_temp) on in_valid/in_ready gives
// exactly one result beat on out_valid/out_ready, in order. A beat is taken
// into an input register, and the validation, setpoint and fan logic run
// between that register and the result register, from which the result is
// offered. One beat is taken every cycle while out_ready is high; the
// multiplier on the loss term in the heater setpoint sets the path.
// A result waiting in the output register does not block the input register,
// so one more beat is taken while out_ready is low; after that in_ready drops
// until the result is taken. Configuration beats on cfg_valid/cfg_ready are
// always taken and must be sent while the block is idle. Reset loads the
// default register values, clears the held readings, turns the heater on,
// the fan off and sets the tick counter to 20000 (or its maximum).
// ----------------------------------------------------------------------------
module incubator_heater_fan_control #(
	parameter int TEMP_WIDTH = ihfc_pkg::TEMP_WIDTH_DEF,
	parameter int TICK_WIDTH = ihfc_pkg::TICK_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [TEMP_WIDTH-1:0]         inside_temp,
	input  logic signed [TEMP_WIDTH-1:0]         water_temp,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 heater_on,
	output logic                                 fan_on,
	output logic signed [TEMP_WIDTH-1:0]         checked_inside,
	output logic signed [TEMP_WIDTH-1:0]         checked_water,
	output logic                                 inside_fault,
	output logic                                 water_fault,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ihfc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [ihfc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int EW  = (TEMP_WIDTH > 12 ? TEMP_WIDTH : 12) + 2;
	localparam int PW  = EW + 12;
	localparam int SW  = PW + 2;
	localparam int CTW = (TICK_WIDTH > 16 ? TICK_WIDTH : 16);
	localparam longint TICK_MAX_L = (64'sd1 <<< TICK_WIDTH) - 64'sd1;
	localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;
	localparam logic [TICK_WIDTH-1:0] TICK_RST =
		(ihfc_pkg::TICK_RESET > TICK_MAX_L) ? TICK_MAX :
		TICK_WIDTH'(ihfc_pkg::TICK_RESET);
	localparam logic signed [EW-1:0] LOW_E  = EW'(ihfc_pkg::LOW_LIMIT);
	localparam logic signed [EW-1:0] HIGH_E = EW'(ihfc_pkg::HIGH_LIMIT);
	localparam logic signed [EW-1:0] LOAD_E = EW'(ihfc_pkg::LOAD_LIMIT);

	logic        [10:0] target_q;
	logic signed [11:0] ambient_q;
	logic        [9:0]  balance_q;
	logic        [10:0] loss_q;
	logic        [7:0]  tol_q;
	logic        [15:0] fan_rest_q;
	logic        [15:0] fan_run_q;
	logic signed [PW-1:0] bal_prod_q;

	logic signed [TEMP_WIDTH-1:0] held_in_q;
	logic signed [TEMP_WIDTH-1:0] held_w_q;
	logic                         heater_q;
	logic                         fan_q;
	logic [TICK_WIDTH-1:0]        tick_q;

	logic                         valid_s1;
	logic signed [TEMP_WIDTH-1:0] inside_s1;
	logic signed [TEMP_WIDTH-1:0] water_s1;

	logic out_free;
	logic advance;

	logic signed [EW-1:0] ins_e;
	logic signed [EW-1:0] wat_e;
	logic signed [EW-1:0] held_in_e;
	logic signed [EW-1:0] held_w_e;
	logic signed [EW-1:0] target_e;
	logic signed [EW-1:0] tol_e;
	logic                 load_both;
	logic                 in_ok;
	logic                 w_ok;
	logic signed [TEMP_WIDTH-1:0] chk_in;
	logic signed [TEMP_WIDTH-1:0] chk_w;
	logic                 in_fault_c;
	logic                 w_fault_c;
	logic signed [EW-1:0] chk_in_e;
	logic signed [EW-1:0] chk_w_e;
	logic signed [EW-1:0] loss_diff;
	logic signed [PW-1:0] loss_prod;
	logic signed [SW-1:0] gain_sum;
	logic signed [SW-1:0] setp;
	logic signed [SW-1:0] water4;
	logic signed [SW-1:0] tol_s;
	logic                 heater_n;
	logic signed [EW+2:0] ins2;
	logic signed [EW+2:0] cool_lim;
	logic                 cool_stop;
	logic                 warm_start;
	logic                 fan_n;
	logic [TICK_WIDTH-1:0] tick_n;

	assign out_free  = !out_valid || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= ihfc_pkg::TARGET_RST;
			ambient_q  <= ihfc_pkg::AMBIENT_RST;
			balance_q  <= ihfc_pkg::BALANCE_RST;
			loss_q     <= ihfc_pkg::LOSS_RST;
			tol_q      <= ihfc_pkg::TOLERANCE_RST;
			fan_rest_q <= ihfc_pkg::FAN_REST_RST;
			fan_run_q  <= ihfc_pkg::FAN_RUN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ihfc_pkg::REG_TARGET:    target_q   <= cfg_data[10:0];
				ihfc_pkg::REG_AMBIENT:   ambient_q  <= $signed(cfg_data[11:0]);
				ihfc_pkg::REG_BALANCE:   balance_q  <= cfg_data[9:0];
				ihfc_pkg::REG_LOSS:      loss_q     <= cfg_data[10:0];
				ihfc_pkg::REG_TOLERANCE: tol_q      <= cfg_data[7:0];
				ihfc_pkg::REG_FAN_REST:  fan_rest_q <= cfg_data[15:0];
				ihfc_pkg::REG_FAN_RUN:   fan_run_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The balance term depends on configuration only, so it is kept ready.
	always_ff @(posedge clk) begin
		bal_prod_q <= PW'($signed({1'b0, balance_q}))
			* (PW'($signed({1'b0, target_q})) - PW'(ambient_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			inside_s1 <= inside_temp;
			water_s1  <= water_temp;
		end
	end

	always_comb begin
		ins_e     = EW'(inside_s1);
		wat_e     = EW'(water_s1);
		held_in_e = EW'(held_in_q);
		held_w_e  = EW'(held_w_q);
		target_e  = $signed(EW'(target_q));
		tol_e     = $signed(EW'(tol_q));

		load_both  = (held_in_e < LOAD_E) && (held_w_e < LOAD_E);
		in_ok      = (ins_e > LOW_E) && (ins_e < HIGH_E);
		w_ok       = (wat_e > LOW_E) && (wat_e < HIGH_E);
		in_fault_c = !load_both && !in_ok;
		w_fault_c  = !load_both && !w_ok;
		chk_in     = in_fault_c ? held_in_q : inside_s1;
		chk_w      = w_fault_c ? held_w_q : water_s1;
		chk_in_e   = EW'(chk_in);
		chk_w_e    = EW'(chk_w);

		loss_diff = target_e - chk_in_e;
		loss_prod = PW'($signed({1'b0, loss_q})) * PW'(loss_diff);
		gain_sum  = SW'(bal_prod_q) + SW'(loss_prod);
		setp      = (SW'(target_e) <<< 2) + (gain_sum >>> 6);
		water4    = SW'(chk_w_e) <<< 2;
		tol_s     = SW'(tol_e);

		heater_n = heater_q;
		if (water4 + tol_s < setp) begin
			heater_n = 1'b1;
		end
		if (water4 - tol_s > setp) begin
			heater_n = 1'b0;
		end

		ins2       = (EW+3)'(chk_in_e) <<< 1;
		cool_lim   = ((EW+3)'(target_e) <<< 1) - (EW+3)'(tol_e) * (EW+3)'(3);
		cool_stop  = ins2 < cool_lim;
		warm_start = chk_in_e > (target_e - tol_e);

		fan_n  = fan_q;
		tick_n = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
		if (cool_stop) begin
			if (fan_n) begin
				tick_n = '0;
			end
			fan_n = 1'b0;
		end
		if (warm_start && (CTW'(tick_n) > CTW'(fan_rest_q)) && !fan_n) begin
			fan_n  = 1'b1;
			tick_n = '0;
		end
		if ((CTW'(tick_n) > CTW'(fan_run_q)) && fan_n) begin
			fan_n  = 1'b0;
			tick_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_in_q <= '0;
			held_w_q  <= '0;
			heater_q  <= 1'b1;
			fan_q     <= 1'b0;
			tick_q    <= TICK_RST;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				held_in_q <= chk_in;
				held_w_q  <= chk_w;
				heater_q  <= heater_n;
				fan_q     <= fan_n;
				tick_q    <= tick_n;
			end
			if (out_free) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heater_on      <= heater_n;
			fan_on         <= fan_n;
			checked_inside <= chk_in;
			checked_water  <= chk_w;
			inside_fault   <= in_fault_c;
			water_fault    <= w_fault_c;
		end
	end

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(heater_q) && $stable(fan_q) && $stable(tick_q)
			&& $stable(held_in_q) && $stable(held_w_q))
		else $error("controller state changed without an item");

	a_fan_clears_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(fan_q) || $fell(fan_q)) |-> tick_q == '0)
		else $error("fan switched without clearing the tick counter");

	a_ticks_drop_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q < $past(tick_q)) |-> tick_q == '0)
		else $error("tick counter decreased to a nonzero value");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled while a stage was free");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Incubator heater and fan control testbench
// Sends temperature readings and register writes over the valid/ready
// channels, predicts each result beat from a cycle-free model of the
// controller, and compares every beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

	localparam int TW = ihfc_pkg::TEMP_WIDTH_DEF;
	localparam int KW = ihfc_pkg::TICK_WIDTH_DEF;
	localparam int IW = ihfc_pkg::CFG_INDEX_WIDTH;
	localparam int DW = ihfc_pkg::CFG_DATA_WIDTH;
	localparam logic [IW-1:0] REG_SPARE = 3'd7;
	localparam logic [KW-1:0] TICK_MAX = '1;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_PCT = 33;

	typedef struct packed {
		logic          heater;
		logic          fan;
		logic [TW-1:0] inside_val;
		logic [TW-1:0] water;
		logic          inside_flt;
		logic          water_flt;
	} control_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [TW-1:0] inside_temp = '0;
	logic signed [TW-1:0] water_temp = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 heater_on;
	logic                 fan_on;
	logic signed [TW-1:0] checked_inside;
	logic signed [TW-1:0] checked_water;
	logic                 inside_fault;
	logic                 water_fault;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IW-1:0]        cfg_index = '0;
	logic [DW-1:0]        cfg_data = '0;

	bit          idle_on = 1'b0;
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned errors = 0;
	control_beat_t due_readings[$];

	logic        [10:0]   m_target = ihfc_pkg::TARGET_RST;
	logic signed [11:0]   m_ambient = ihfc_pkg::AMBIENT_RST;
	logic        [9:0]    m_balance = ihfc_pkg::BALANCE_RST;
	logic        [10:0]   m_loss = ihfc_pkg::LOSS_RST;
	logic        [7:0]    m_tol = ihfc_pkg::TOLERANCE_RST;
	logic        [15:0]   m_rest = ihfc_pkg::FAN_REST_RST;
	logic        [15:0]   m_run = ihfc_pkg::FAN_RUN_RST;
	logic signed [TW-1:0] m_held_in = '0;
	logic signed [TW-1:0] m_held_wat = '0;
	logic                 m_heater = 1'b1;
	logic                 m_fan = 1'b0;
	logic [KW-1:0]        m_ticks = (ihfc_pkg::TICK_RESET > longint'(TICK_MAX)) ?
		TICK_MAX : KW'(ihfc_pkg::TICK_RESET);

	incubator_heater_fan_control i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.inside_temp    (inside_temp),
		.water_temp     (water_temp),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.heater_on      (heater_on),
		.fan_on         (fan_on),
		.checked_inside (checked_inside),
		.checked_water  (checked_water),
		.inside_fault   (inside_fault),
		.water_fault    (water_fault),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit in_window(longint v);
		return v > ihfc_pkg::LOW_LIMIT && v < ihfc_pkg::HIGH_LIMIT;
	endfunction

	function automatic void apply_setting(logic [IW-1:0] idx, logic [DW-1:0] data);
		case (idx)
			ihfc_pkg::REG_TARGET:    m_target = data[10:0];
			ihfc_pkg::REG_AMBIENT:   m_ambient = data[11:0];
			ihfc_pkg::REG_BALANCE:   m_balance = data[9:0];
			ihfc_pkg::REG_LOSS:      m_loss = data[10:0];
			ihfc_pkg::REG_TOLERANCE: m_tol = data[7:0];
			ihfc_pkg::REG_FAN_REST:  m_rest = data[15:0];
			ihfc_pkg::REG_FAN_RUN:   m_run = data[15:0];
			default: begin
			end
		endcase
	endfunction

	function automatic control_beat_t predict_control(logic signed [TW-1:0] raw_in,
		logic signed [TW-1:0] raw_wat);
		control_beat_t beat;
		longint ins, wat, tgt, tol, setp;
		beat = '0;
		ins = raw_in;
		wat = raw_wat;
		if (m_held_in < ihfc_pkg::LOAD_LIMIT && m_held_wat < ihfc_pkg::LOAD_LIMIT) begin
			m_held_in = raw_in;
			m_held_wat = raw_wat;
		end else begin
			if (in_window(ins)) begin
				m_held_in = raw_in;
			end else begin
				ins = m_held_in;
				beat.inside_flt = 1'b1;
			end
			if (in_window(wat)) begin
				m_held_wat = raw_wat;
			end else begin
				wat = m_held_wat;
				beat.water_flt = 1'b1;
			end
		end

		tgt = m_target;
		tol = m_tol;
		setp = 4 * tgt + ((longint'(m_balance) * (tgt - longint'(m_ambient))
			+ longint'(m_loss) * (tgt - ins)) >>> 6);
		if (4 * wat + tol < setp) begin
			m_heater = 1'b1;
		end
		if (4 * wat - tol > setp) begin
			m_heater = 1'b0;
		end

		if (m_ticks != TICK_MAX) begin
			m_ticks = m_ticks + 1'b1;
		end
		if (2 * ins < 2 * tgt - 3 * tol) begin
			if (m_fan) begin
				m_ticks = '0;
			end
			m_fan = 1'b0;
		end
		if (ins > tgt - tol && m_ticks > m_rest && !m_fan) begin
			m_fan = 1'b1;
			m_ticks = '0;
		end
		if (m_ticks > m_run && m_fan) begin
			m_fan = 1'b0;
			m_ticks = '0;
		end

		beat.heater = m_heater;
		beat.fan = m_fan;
		beat.inside_val = ins[TW-1:0];
		beat.water = wat[TW-1:0];
		return beat;
	endfunction

	function automatic logic signed [TW-1:0] random_temp();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 80) begin
			return TW'($urandom_range(ihfc_pkg::HIGH_LIMIT - 1, ihfc_pkg::LOW_LIMIT + 1));
		end
		if (pick < 90) begin
			case ($urandom_range(3))
				0: return TW'(ihfc_pkg::LOW_LIMIT);
				1: return TW'(ihfc_pkg::HIGH_LIMIT);
				2: return {1'b1, {(TW-1){1'b0}}};
				default: return {1'b0, {(TW-1){1'b1}}};
			endcase
		end
		return TW'($urandom);
	endfunction

	task automatic send_reading(input logic signed [TW-1:0] raw_in,
		input logic signed [TW-1:0] raw_wat);
		if (idle_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		inside_temp <= raw_in;
		water_temp <= raw_wat;
		do @(posedge clk); while (!in_ready);
		due_readings.push_back(predict_control(raw_in, raw_wat));
	endtask

	task automatic wait_idle;
		in_valid <= 1'b0;
		while (due_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, data);
	endtask

	// Unused upper data bits carry noise so that masking is exercised too.
	task automatic set_all(input int target, ambient, balance, loss, tol, rest, run);
		logic [DW-1:0] noise;
		noise = $urandom;
		wait_idle();
		write_reg(ihfc_pkg::REG_TARGET, {noise[15:11], 11'(target)});
		write_reg(ihfc_pkg::REG_AMBIENT, {noise[15:12], 12'(ambient)});
		write_reg(ihfc_pkg::REG_BALANCE, {noise[15:10], 10'(balance)});
		write_reg(ihfc_pkg::REG_LOSS, {noise[15:11], 11'(loss)});
		write_reg(ihfc_pkg::REG_TOLERANCE, {noise[15:8], 8'(tol)});
		write_reg(ihfc_pkg::REG_FAN_REST, 16'(rest));
		write_reg(ihfc_pkg::REG_FAN_RUN, 16'(run));
		write_reg(REG_SPARE, noise);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_initial_load;
		send_reading(-2048, -2048);
		send_reading(7, 7);
		send_reading(2047, 5);
		send_reading(-2048, 300);
		send_reading(160, 640);
		send_reading(161, 639);
		send_reading(640, 160);
	endtask

	task automatic test_register_extremes;
		set_all(0, -880, 0, 0, 0, 0, 0);
		send_reading(300, 200);
		send_reading(-1, 0);
		set_all(1600, 2000, 1023, 2047, 255, 65534, 65534);
		send_reading(200, 300);
		send_reading(639, 161);
		set_all(ihfc_pkg::TARGET_RST, ihfc_pkg::AMBIENT_RST, ihfc_pkg::BALANCE_RST,
			ihfc_pkg::LOSS_RST, ihfc_pkg::TOLERANCE_RST, ihfc_pkg::FAN_REST_RST,
			ihfc_pkg::FAN_RUN_RST);
	endtask

	task automatic test_heater_band;
		set_all(400, 400, 0, 0, 8, 65534, 65534);
		send_reading(400, 403);
		send_reading(400, 398);
		send_reading(400, 397);
		send_reading(400, 402);
		send_reading(400, 403);
		// A negative setpoint term has to round down, not toward zero.
		set_all(400, 400, 0, 5, 8, 65534, 65534);
		send_reading(500, 403);
		send_reading(500, 396);
		send_reading(500, 395);
	endtask

	task automatic test_fan_timing;
		set_all(400, 288, 46, 640, 16, 3, 5);
		repeat (8) send_reading(390, 400);
		repeat (2) send_reading(370, 400);
		repeat (2) send_reading(380, 400);
		repeat (2) send_reading(390, 400);
		set_all(400, 288, 46, 640, 0, 0, 0);
		repeat (3) send_reading(401, 400);
		send_reading(399, 400);
	endtask

	task automatic test_back_pressure;
		set_all(420, 200, 300, 900, 12, 4, 6);
		hold_asks <= hold_asks + 1;
		idle_on <= 1'b0;
		repeat (24) send_reading(random_temp(), random_temp());
		wait_idle();
		repeat (8) send_reading(random_temp(), random_temp());
		idle_on <= 1'b1;
	endtask

	task automatic test_random;
		for (int phase = 0; phase < 8; phase++) begin
			if ($urandom_range(3) == 0) begin
				set_all($urandom_range(1600), int'($urandom_range(2880)) - 880,
					$urandom_range(1023), $urandom_range(2047), $urandom_range(255),
					$urandom_range(65534), $urandom_range(65534));
			end else begin
				set_all($urandom_range(560, 240), $urandom_range(500, 200),
					$urandom_range(1023), $urandom_range(2047), $urandom_range(40),
					$urandom_range(40), $urandom_range(40));
			end
			idle_on <= (phase != 3);
			repeat (110) send_reading(random_temp(), random_temp());
		end
	endtask

	always @(posedge clk) begin
		if (hold_served != hold_asks) begin
			hold_served <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic check_field(input string what, input logic signed [TW:0] want, got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		control_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_readings.size() == 0) begin
				errors++;
				$display("%0t: result beat expected none, got one", $time);
			end else begin
				want = due_readings.pop_front();
				check_field("heater_on", want.heater, heater_on);
				check_field("fan_on", want.fan, fan_on);
				check_field("checked_inside", $signed(want.inside_val), checked_inside);
				check_field("checked_water", $signed(want.water), checked_water);
				check_field("inside_fault", want.inside_flt, inside_fault);
				check_field("water_fault", want.water_flt, water_fault);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		idle_on <= 1'b1;
		test_initial_load();
		test_register_extremes();
		test_heater_band();
		test_fan_timing();
		test_back_pressure();
		test_random();
		wait_idle();
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
